### design/tif_pkg.sv
// shared types and byte codes for the telnet IAC filter
`timescale 1ns / 1ps

package tif_pkg;

    // telnet command bytes
    localparam logic [7:0] B_IAC  = 8'hFF;
    localparam logic [7:0] B_DONT = 8'hFE;
    localparam logic [7:0] B_DO   = 8'hFD;
    localparam logic [7:0] B_WONT = 8'hFC;
    localparam logic [7:0] B_WILL = 8'hFB;
    localparam logic [7:0] B_SB   = 8'hFA;
    localparam logic [7:0] B_EL   = 8'hF8;
    localparam logic [7:0] B_EC   = 8'hF7;
    localparam logic [7:0] B_IP   = 8'hF4;
    localparam logic [7:0] B_BRK  = 8'hF3;
    localparam logic [7:0] B_SE   = 8'hF0;

    // substituted control characters
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_NAK = 8'h15;

    // option codes
    localparam logic [7:0] OPT_BINARY = 8'h00;
    localparam logic [7:0] OPT_ECHO   = 8'h01;
    localparam logic [7:0] OPT_SGA    = 8'h03;

    // result kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // one received byte with its sideband
    typedef struct packed {
        logic       refuse_client_echo;
        logic       chunk_end;
        logic [7:0] in_byte;
    } item_t;

    // one filter result
    typedef struct packed {
        logic       kind;
        logic [7:0] reply_option;
        logic [7:0] reply_verb;
        logic [7:0] data_byte;
    } result_t;

    // options that get a positive answer
    function automatic logic opt_accepted(input logic [7:0] opt);
        opt_accepted = (opt == OPT_BINARY) || (opt == OPT_ECHO) || (opt == OPT_SGA);
    endfunction

endpackage

### design/telnet_iac_filter_unit.sv
// top level of the telnet IAC filter
//
//  channel  | direction | tdata                         | tuser              | tlast
//  s_axis   | in        | [7:0] in_byte                 | refuse_client_echo | chunk_end
//  m_axis   | out       | [7:0] data_byte, [15:8] verb, | kind               | -
//           |           | [23:16] reply_option          |                    |
//
// one byte per cycle sustained while m_axis does not stall; each byte is decoded while it
// sits in the input register, and its result passes through the result register to m_axis
// a byte that yields no result is consumed without an output transaction
// reset clears both valid flags and returns the parser to plain data
// a stall on m_axis holds the result register and backs up into the input register
`timescale 1ns / 1ps

module telnet_iac_filter_unit
    import tif_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // [0] refuse_client_echo
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [15:8] reply_verb, [23:16] reply_option
    output logic        m_axis_tuser    // [0] kind
);

    item_t   s_item;
    item_t   held_item;
    logic    held_valid;
    logic    can_load;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign s_item.in_byte            = s_axis_tdata;
    assign s_item.chunk_end          = s_axis_tlast;
    assign s_item.refuse_client_echo = s_axis_tuser;

    // a held byte is decoded when the result register has room
    assign step = held_valid && can_load;

    tif_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .take    (step),
        .valid   (held_valid),
        .item    (held_item)
    );

    tif_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    tif_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .can_load   (can_load),
        .load       (step),
        .load_valid (res_valid),
        .load_res   (res),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_res      (m_res)
    );

    // output transaction packing
    assign m_axis_tdata = {m_res.reply_option, m_res.reply_verb, m_res.data_byte};
    assign m_axis_tuser = m_res.kind;

endmodule

### design/tif_in_reg.sv
// input register stage holding one received byte
`timescale 1ns / 1ps

module tif_in_reg
    import tif_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  take,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // free when empty or when the held item leaves this cycle
    assign s_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_ready)
        begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload loads on an accepted transaction
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

### design/tif_parser.sv
// parse state register and per-byte decode of telnet sequences
`timescale 1ns / 1ps

module tif_parser
    import tif_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    localparam logic [2:0] ST_PLAIN    = 3'd0;
    localparam logic [2:0] ST_IAC      = 3'd1;
    localparam logic [2:0] ST_OPT_DO   = 3'd2;
    localparam logic [2:0] ST_OPT_WILL = 3'd3;
    localparam logic [2:0] ST_OPT_SKIP = 3'd4;
    localparam logic [2:0] ST_SB       = 3'd5;
    localparam logic [2:0] ST_SB_IAC   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] parse_next;
    logic [7:0] b;
    logic       will_ok;

    assign b       = item.in_byte;
    assign will_ok = opt_accepted(b) && !(item.refuse_client_echo && (b == OPT_ECHO));

    // decode one byte against the current state
    always_comb
    begin
        parse_next = ST_PLAIN;
        res_valid  = 1'b0;
        res        = '0;
        unique case (state_reg)
            ST_IAC:
            begin
                unique case (b)
                    B_IAC:
                    begin
                        res_valid     = 1'b1;
                        res.data_byte = B_IAC;
                    end
                    B_DO:           parse_next = ST_OPT_DO;
                    B_WILL:         parse_next = ST_OPT_WILL;
                    B_DONT, B_WONT: parse_next = ST_OPT_SKIP;
                    B_SB:           parse_next = ST_SB;
                    B_IP, B_BRK:
                    begin
                        res_valid     = 1'b1;
                        res.data_byte = CH_ETX;
                    end
                    B_EC:
                    begin
                        res_valid     = 1'b1;
                        res.data_byte = CH_BS;
                    end
                    B_EL:
                    begin
                        res_valid     = 1'b1;
                        res.data_byte = CH_NAK;
                    end
                    default:        parse_next = ST_PLAIN;
                endcase
            end
            ST_OPT_DO:
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_REPLY;
                res.reply_verb   = opt_accepted(b) ? B_WILL : B_WONT;
                res.reply_option = b;
            end
            ST_OPT_WILL:
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_REPLY;
                res.reply_verb   = will_ok ? B_DO : B_DONT;
                res.reply_option = b;
            end
            ST_OPT_SKIP:
            begin
                parse_next = ST_PLAIN;
            end
            ST_SB:
            begin
                parse_next = (b == B_IAC) ? ST_SB_IAC : ST_SB;
            end
            ST_SB_IAC:
            begin
                if (b == B_SE)
                begin
                    parse_next = ST_PLAIN;
                end
                else if (b == B_IAC)
                begin
                    parse_next = ST_SB_IAC;
                end
                else
                begin
                    parse_next = ST_SB;
                end
            end
            default:
            begin
                if (b == B_IAC)
                begin
                    parse_next = ST_IAC;
                end
                else
                begin
                    res_valid     = 1'b1;
                    res.kind      = KIND_DATA;
                    res.data_byte = b;
                end
            end
        endcase
    end

    // chunk end drops any unfinished sequence
    always_comb
    begin
        state_next = state_reg;
        if (step)
        begin
            state_next = item.chunk_end ? ST_PLAIN : parse_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PLAIN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/tif_out_reg.sv
// result register feeding the output stream
`timescale 1ns / 1ps

module tif_out_reg
    import tif_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    output logic    can_load,
    input  logic    load,
    input  logic    load_valid,
    input  result_t load_res,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // room when empty or when the held result is taken this cycle
    assign can_load = !valid_reg || m_ready;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = load_valid;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
        begin
            res_reg <= load_res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

### dv/tb_top.sv
// self-checking testbench for the telnet IAC filter unit
`timescale 1ns / 1ps

module tb_top;
    import tif_pkg::*;

    // parser states of the prediction
    typedef enum logic [2:0] {
        PS_PLAIN,
        PS_IAC,
        PS_OPT_DO,
        PS_OPT_WILL,
        PS_OPT_SKIP,
        PS_SB,
        PS_SB_IAC
    } parse_state_e;

    localparam int RANDOM_ITEMS = 1250;
    localparam int DRAIN_CYCLES = 8;
    localparam int SINK_HOLD_CYCLES = 300;

    // expected filter output and its comparison against the bus
    class iac_scoreboard;
        parse_state_e parse_st;
        result_t      expected_results[$];
        int           err_count;

        function new();
            parse_st  = PS_PLAIN;
            err_count = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void report(string msg);
            err_count++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        function logic accepts_option(logic [7:0] opt);
            return (opt == OPT_BINARY) || (opt == OPT_ECHO) || (opt == OPT_SGA);
        endfunction

        // advance the parser on one accepted byte and queue any output it yields
        function void note_byte(logic [7:0] b, logic last, logic refuse);
            result_t      r;
            parse_state_e nxt;
            logic         hit;
            logic         ok;
            r   = '0;
            nxt = PS_PLAIN;
            hit = 1'b0;
            case (parse_st)
                PS_IAC:
                begin
                    case (b)
                        B_IAC:
                        begin
                            hit = 1'b1;
                            r.data_byte = B_IAC;
                        end
                        B_DO:   nxt = PS_OPT_DO;
                        B_WILL: nxt = PS_OPT_WILL;
                        B_DONT, B_WONT: nxt = PS_OPT_SKIP;
                        B_SB:   nxt = PS_SB;
                        B_IP, B_BRK:
                        begin
                            hit = 1'b1;
                            r.data_byte = CH_ETX;
                        end
                        B_EC:
                        begin
                            hit = 1'b1;
                            r.data_byte = CH_BS;
                        end
                        B_EL:
                        begin
                            hit = 1'b1;
                            r.data_byte = CH_NAK;
                        end
                        default: ;
                    endcase
                end
                PS_OPT_DO:
                begin
                    hit = 1'b1;
                    r.kind = KIND_REPLY;
                    r.reply_verb = accepts_option(b) ? B_WILL : B_WONT;
                    r.reply_option = b;
                end
                PS_OPT_WILL:
                begin
                    ok = accepts_option(b) && !(refuse && (b == OPT_ECHO));
                    hit = 1'b1;
                    r.kind = KIND_REPLY;
                    r.reply_verb = ok ? B_DO : B_DONT;
                    r.reply_option = b;
                end
                PS_OPT_SKIP: ;
                PS_SB:
                    nxt = (b == B_IAC) ? PS_SB_IAC : PS_SB;
                PS_SB_IAC:
                begin
                    if (b == B_SE)
                        nxt = PS_PLAIN;
                    else if (b == B_IAC)
                        nxt = PS_SB_IAC;
                    else
                        nxt = PS_SB;
                end
                default:
                begin
                    if (b == B_IAC)
                        nxt = PS_IAC;
                    else
                    begin
                        hit = 1'b1;
                        r.data_byte = b;
                    end
                end
            endcase
            if (hit)
                expected_results.push_back(r);
            parse_st = last ? PS_PLAIN : nxt;
        endfunction

        // compare one output transaction with the oldest expectation
        function void check_result(result_t got);
            result_t exp_r;
            if (expected_results.size() == 0)
            begin
                report($sformatf("unexpected output kind=%0d tdata=%h", got.kind,
                                 {got.reply_option, got.reply_verb, got.data_byte}));
                return;
            end
            exp_r = expected_results.pop_front();
            if (got.kind !== exp_r.kind)
                report($sformatf("kind got %0d exp %0d", got.kind, exp_r.kind));
            if (got.data_byte !== exp_r.data_byte)
                report($sformatf("data_byte got %h exp %h", got.data_byte, exp_r.data_byte));
            if (got.reply_verb !== exp_r.reply_verb)
                report($sformatf("reply_verb got %h exp %h", got.reply_verb, exp_r.reply_verb));
            if (got.reply_option !== exp_r.reply_option)
                report($sformatf("reply_option got %h exp %h", got.reply_option,
                                 exp_r.reply_option));
        endfunction

        function void check_leftovers();
            if (expected_results.size() != 0)
                report($sformatf("%0d expected outputs never arrived",
                                 expected_results.size()));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    iac_scoreboard sb;
    bit            src_idle_en = 1'b1;
    bit            sink_idle_en = 1'b1;
    int            sink_hold_len = 0;
    int            sent_count = 0;

    telnet_iac_filter_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #2 clk = ~clk;

    // watch both channels; input transactions are noted before outputs are checked
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind = m_axis_tuser;
                {got.reply_option, got.reply_verb, got.data_byte} = m_axis_tdata;
                sb.check_result(got);
            end
        end
    end

    // receiver with random stalls and a single long hold-off
    initial
    begin : sink_proc
        forever
        begin
            @(posedge clk);
            if (sink_hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold_len--;
            end
            else
                m_axis_tready <= !(sink_idle_en && ($urandom_range(99) < 19));
        end
    end

    // offer one byte, idling at random first, and wait for its transaction
    task automatic send_byte(input logic [7:0] b, input logic last, input logic refuse);
        while (src_idle_en && ($urandom_range(99) < 19))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        s_axis_tuser  <= refuse;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
    endtask

    // random sideband for one byte
    task automatic send_rand_side(input logic [7:0] b);
        send_byte(b, $urandom_range(15) == 0, 1'($urandom_range(1)));
    endtask

    // stop offering until every expected output has come back
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_option();
        case ($urandom_range(3))
            0: return OPT_BINARY;
            1: return OPT_ECHO;
            2: return OPT_SGA;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // one mostly well-formed stretch of the telnet stream
    task automatic send_random_sequence();
        int n;
        logic [7:0] cmd;
        case ($urandom_range(9))
            0, 1, 2:
                send_rand_side(8'($urandom_range(254)));
            3:
            begin
                send_rand_side(B_IAC);
                case ($urandom_range(5))
                    0: cmd = B_IAC;
                    1: cmd = B_IP;
                    2: cmd = B_BRK;
                    3: cmd = B_EC;
                    4: cmd = B_EL;
                    default: cmd = 8'($urandom_range(8'hF0, 8'hFF));
                endcase
                send_rand_side(cmd);
            end
            4, 5:
            begin
                send_rand_side(B_IAC);
                send_rand_side(($urandom_range(1) == 0) ? B_DO : B_WILL);
                send_rand_side(pick_option());
            end
            6:
            begin
                send_rand_side(B_IAC);
                send_rand_side(($urandom_range(1) == 0) ? B_DONT : B_WONT);
                send_rand_side(pick_option());
            end
            7:
            begin
                // subnegotiation with random body, sometimes escaped iac runs
                send_rand_side(B_IAC);
                send_rand_side(B_SB);
                n = $urandom_range(6);
                repeat (n)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        send_rand_side(B_IAC);
                        send_rand_side(B_IAC);
                    end
                    else
                        send_rand_side(8'($urandom_range(255)));
                end
                send_rand_side(B_IAC);
                send_rand_side(B_SE);
            end
            default:
            begin
                // noise
                n = $urandom_range(1, 4);
                repeat (n) send_rand_side(8'($urandom_range(255)));
            end
        endcase
    endtask

    // main stimulus
    initial
    begin : stimulus
        bit held;
        bit paused;
        int target;
        held   = 1'b0;
        paused = 1'b0;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every command but dont, and the chunk-end cases
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b1);
        send_byte(B_IP,  1'b0, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_BRK, 1'b0, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_EC,  1'b0, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_EL,  1'b1, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_DO,  1'b0, 1'b0);
        send_byte(8'h05, 1'b0, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b1);
        send_byte(B_WILL, 1'b0, 1'b1);
        send_byte(OPT_ECHO, 1'b0, 1'b1);
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_WONT, 1'b0, 1'b0);
        send_byte(OPT_SGA, 1'b0, 1'b0);
        // subnegotiation closed by a run of iac bytes before se
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_SB,  1'b0, 1'b0);
        send_byte(8'h18, 1'b0, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(B_SE,  1'b0, 1'b0);
        // unknown command dropped, then a lone iac cut off by chunk end
        send_byte(B_IAC, 1'b0, 1'b0);
        send_byte(8'hF1, 1'b0, 1'b0);
        send_byte(B_IAC, 1'b1, 1'b0);
        send_byte(8'hFE, 1'b0, 1'b1);
        drain_outputs();

        // random traffic with a stretch without idles, a long sink stall and a sender pause
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target)
        begin
            src_idle_en  = !((sent_count >= target - 850) && (sent_count < target - 600));
            sink_idle_en = src_idle_en;
            if (!held && (sent_count >= target - 450))
            begin
                sink_hold_len = SINK_HOLD_CYCLES;
                held = 1'b1;
            end
            if (!paused && (sent_count >= target - 250))
            begin
                drain_outputs();
                paused = 1'b1;
            end
            send_random_sequence();
        end
        drain_outputs();

        sb.check_leftovers();
        if (sb.err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
